[rtl/epdmd_pkg.sv]
// Shared constants, codes and types of the encoder position PD motor drive.
package epdmd_pkg;

  localparam int STABLE_TICKS = 10;
  localparam int PWM_FULL     = 1023;
  localparam int DUTY_TOP     = 1023;

  localparam int WORD_W    = 32;
  localparam int DUTY_W    = 10;
  localparam int DT_W      = 20;
  localparam int COUNT_W   = 8;
  localparam int REG_IDX_W = 3;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;
  localparam logic CHAN_A   = 1'b0;
  localparam logic CHAN_B   = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TARGET,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_CW_MIN,
    REG_CW_MAX,
    REG_CCW_MIN,
    REG_CCW_MAX
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MAG,
    S_MUL_P,
    S_MUL_G,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_TERM,
    S_ACC,
    S_SHAPE,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [DUTY_W-1:0] pwm_duty;
    logic              direction;
    logic              finished;
    logic              last;
  } result_t;

endpackage

[rtl/epdmd_if.sv]
// Handshake channels for the request items and result items of the motor drive.
interface epdmd_req_if;
  import epdmd_pkg::*;

  logic            valid;
  logic            ready;
  logic            cmd;
  logic            edge_channel;
  logic            level_a;
  logic            level_b;
  logic [DT_W-1:0] elapsed_us;

  modport source (output valid, cmd, edge_channel, level_a, level_b, elapsed_us,
                  input ready);
  modport sink   (input valid, cmd, edge_channel, level_a, level_b, elapsed_us,
                  output ready);
endinterface

interface epdmd_res_if;
  import epdmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] pwm_duty;
  logic              direction;
  logic              finished;
  logic              last;

  modport source (output valid, pwm_duty, direction, finished, last, input ready);
  modport sink   (input valid, pwm_duty, direction, finished, last, output ready);
endinterface

[rtl/encoder_position_pd_motor_drive.sv]
// Top level of the encoder position PD motor drive: counter, controller and sequencer.
//
// The block counts quadrature edges into a signed 32-bit position and, on each
// control tick, works out control = p*e + i*e*dt + d*(e - previous error)*dt in
// signed Q16.16 with saturation to 64 bits, then turns it into a direction level
// and a 10-bit PWM duty. An edge item is taken while idle and gives no result.
// A tick item occupies the block from acceptance until its first result is
// shown: one 32 by 32 bit unsigned multiplier is shared by all seven partial
// products of the control law and is stepped by a small sequencer, one product
// per cycle, with the saturating adds in the cycles between. Results then wait
// in an output register until taken; a tick that completes the stability run
// gives two results back to back. Once finished, a tick goes from idle straight
// to the output state and gives one stop result. The request channel is not ready
// while a tick is in progress or a result is waiting. Configuration registers
// are written through a plain write port and take effect on the next tick; the
// block has no memories and needs no clearing pass after reset.
module encoder_position_pd_motor_drive (
  input  logic                     clk,
  input  logic                     rst,
  epdmd_req_if.sink                request,
  epdmd_res_if.source              result,
  input  logic                     write_enable,
  input  epdmd_pkg::reg_idx_t      reg_index,
  input  logic [epdmd_pkg::WORD_W-1:0] write_data
);
  import epdmd_pkg::*;

  localparam logic [DUTY_W-1:0]  PWM_FULL_DUTY = DUTY_W'(PWM_FULL);
  localparam logic [DUTY_W-1:0]  DUTY_TOP_V    = DUTY_W'(DUTY_TOP);
  localparam logic [COUNT_W-1:0] STABLE_LIMIT  = COUNT_W'(STABLE_TICKS);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [WORD_W-1:0] S32_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] S32_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Configuration registers.
  logic signed [WORD_W-1:0] target_position;
  logic signed [WORD_W-1:0] gain_p;
  logic signed [WORD_W-1:0] gain_i;
  logic signed [WORD_W-1:0] gain_d;
  logic [DUTY_W-1:0]        cw_min_duty;
  logic [DUTY_W-1:0]        cw_max_duty;
  logic [DUTY_W-1:0]        ccw_min_mag;
  logic [DUTY_W-1:0]        ccw_max_mag;

  // Architectural state.
  logic [WORD_W-1:0]        position;
  logic signed [WORD_W-1:0] previous_error;
  logic [COUNT_W-1:0]       stable_count;
  logic                     done_flag;

  state_t state, state_next;
  logic   in_acc;
  logic   out_acc;
  logic   second_pending;
  logic   phase;              // low for the integral term, high for the derivative term

  // Datapath registers.
  logic [DT_W-1:0]          dt;
  logic signed [WORD_W-1:0] err;
  logic [WORD_W-1:0]        err_mag;
  logic                     err_neg;
  logic signed [WORD_W:0]   diff;
  logic [WORD_W-1:0]        diff_mag;
  logic                     diff_neg;
  logic [WORD_W-1:0]        g_mag;
  logic                     g_neg;
  logic                     term_neg;
  logic [63:0]              prod;
  logic [WORD_W-1:0]        part_hi;
  logic [51:0]              part_lo;
  logic [51:0]              sum_hi;
  logic [WORD_W-1:0]        sum_lo;
  logic signed [63:0]       term;
  logic signed [63:0]       acc;
  logic                     ctl_pos;
  logic [63:0]              ctl_mag;
  result_t                  out_q;

  // Shared multiplier operands.
  logic [WORD_W-1:0] mul_a;
  logic [WORD_W-1:0] mul_b;

  // Combinational helpers.
  logic [WORD_W:0]   err_wide;
  logic [64:0]       acc_sum;
  logic [63:0]       term_m;
  logic [47:0]       ctl_int;
  logic              ctl_big;
  logic [DUTY_W-1:0] ctl_low;
  logic [DUTY_W-1:0] cw_hi_clamp;
  logic [DUTY_W-1:0] cw_duty;
  logic [DUTY_W-1:0] ccw_hi_clamp;
  logic [DUTY_W-1:0] ccw_mag;
  logic [COUNT_W-1:0] count_inc;
  logic              pos_down;

  assign in_acc  = request.valid && request.ready;
  assign out_acc = result.valid && result.ready;

  assign result.pwm_duty  = out_q.pwm_duty;
  assign result.direction = out_q.direction;
  assign result.finished  = out_q.finished;
  assign result.last      = out_q.last;

  // Configuration write port; all eight indexes name a register, so the default arm is never taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      target_position <= '0;
      gain_p          <= 32'sd65536;
      gain_i          <= 32'sd66;
      gain_d          <= 32'sd66;
      cw_min_duty     <= 10'd50;
      cw_max_duty     <= 10'd600;
      ccw_min_mag     <= 10'd600;
      ccw_max_mag     <= 10'd700;
    end else if (write_enable) begin
      case (reg_index)
        REG_TARGET:  target_position <= write_data;
        REG_GAIN_P:  gain_p          <= write_data;
        REG_GAIN_I:  gain_i          <= write_data;
        REG_GAIN_D:  gain_d          <= write_data;
        REG_CW_MIN:  cw_min_duty     <= write_data[DUTY_W-1:0];
        REG_CW_MAX:  cw_max_duty     <= write_data[DUTY_W-1:0];
        REG_CCW_MIN: ccw_min_mag     <= write_data[DUTY_W-1:0];
        REG_CCW_MAX: ccw_max_mag     <= write_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and handshake outputs.
  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    result.valid  = 1'b0;
    case (state)
      S_IDLE: begin
        request.ready = 1'b1;
        if (in_acc && request.cmd == CMD_TICK) begin
          state_next = done_flag ? S_OUT : S_ERR;
        end
      end
      S_ERR:    state_next = S_MAG;
      S_MAG:    state_next = S_MUL_P;
      S_MUL_P:  state_next = S_MUL_G;
      S_MUL_G:  state_next = S_MUL_LO;
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_SUM;
      S_SUM:    state_next = S_TERM;
      S_TERM:   state_next = S_ACC;
      S_ACC:    state_next = phase ? S_SHAPE : S_MUL_G;
      S_SHAPE:  state_next = S_DECIDE;
      S_DECIDE: state_next = S_OUT;
      S_OUT: begin
        result.valid = 1'b1;
        if (result.ready && !second_pending) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // The shared multiplier sees the operands that the current step needs.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_P: begin
        mul_a = g_mag;
        mul_b = err_mag;
      end
      S_MUL_G: begin
        mul_a = g_mag;
        mul_b = phase ? diff_mag : err_mag;
      end
      S_MUL_LO: begin
        mul_a = prod[WORD_W-1:0];
        mul_b = WORD_W'(dt);
      end
      S_MUL_HI: begin
        mul_a = part_hi;
        mul_b = WORD_W'(dt);
      end
      default: ;
    endcase
  end

  // Error as a 33-bit difference, saturated later to 32 bits.
  assign err_wide = {target_position[WORD_W-1], target_position}
                  - {position[WORD_W-1], position};

  // Saturating 64-bit accumulate of the finished term.
  assign acc_sum = {acc[63], acc} + {term[63], term};

  // Magnitude of a dt-scaled term once its two partial products are joined.
  assign term_m = {1'b0, sum_hi[30:0], sum_lo};

  // Integer part of the control magnitude and its clamps.
  assign ctl_int      = ctl_mag[63:16];
  assign ctl_big      = |ctl_int[47:DUTY_W];
  assign ctl_low      = ctl_int[DUTY_W-1:0];
  assign cw_hi_clamp  = (ctl_big || ctl_low > cw_max_duty) ? cw_max_duty : ctl_low;
  assign cw_duty      = (cw_hi_clamp < cw_min_duty) ? cw_min_duty : cw_hi_clamp;
  assign ccw_hi_clamp = (ctl_big || ctl_low > ccw_max_mag) ? ccw_max_mag : ctl_low;
  assign ccw_mag      = (ccw_hi_clamp < ccw_min_mag) ? ccw_min_mag : ccw_hi_clamp;
  assign count_inc    = (stable_count == COUNT_MAX) ? COUNT_MAX : stable_count + 1'b1;

  // Quadrature decode: on line A equal levels count down, on line B they count up.
  assign pos_down = (request.edge_channel == CHAN_A) ? (request.level_a == request.level_b)
                                                     : (request.level_a != request.level_b);

  // Control state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      previous_error <= '0;
      stable_count   <= '0;
      done_flag      <= 1'b0;
      second_pending <= 1'b0;
      phase          <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc && request.cmd == CMD_EDGE) begin
            position <= pos_down ? position - 1'b1 : position + 1'b1;
          end
        end
        S_MAG: begin
          previous_error <= err;
        end
        S_MUL_P: begin
          phase <= 1'b0;
        end
        S_ACC: begin
          phase <= 1'b1;
        end
        S_DECIDE: begin
          if (err == '0) begin
            stable_count <= count_inc;
            if (count_inc >= STABLE_LIMIT) begin
              done_flag      <= 1'b1;
              second_pending <= 1'b1;
            end
          end else begin
            stable_count <= '0;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            second_pending <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; the multiplier output is registered every cycle.
  always_ff @(posedge clk) begin
    prod <= 64'(mul_a * mul_b);
    case (state)
      S_IDLE: begin
        dt    <= request.elapsed_us;
        out_q <= '{pwm_duty: '0, direction: 1'b0, finished: 1'b1, last: 1'b1};
      end
      S_ERR: begin
        if (err_wide[WORD_W] != err_wide[WORD_W-1]) begin
          err <= err_wide[WORD_W] ? S32_MIN : S32_MAX;
        end else begin
          err <= err_wide[WORD_W-1:0];
        end
      end
      S_MAG: begin
        err_neg <= err[WORD_W-1];
        err_mag <= err[WORD_W-1] ? WORD_W'(0) - err : err;
        diff    <= {err[WORD_W-1], err} - {previous_error[WORD_W-1], previous_error};
        g_neg   <= gain_p[WORD_W-1];
        g_mag   <= gain_p[WORD_W-1] ? WORD_W'(0) - gain_p : gain_p;
      end
      S_MUL_P: begin
        term_neg <= g_neg ^ err_neg;
        diff_neg <= diff[WORD_W];
        diff_mag <= diff[WORD_W] ? WORD_W'(0) - diff[WORD_W-1:0] : diff[WORD_W-1:0];
        g_neg    <= gain_i[WORD_W-1];
        g_mag    <= gain_i[WORD_W-1] ? WORD_W'(0) - gain_i : gain_i;
      end
      S_MUL_G: begin
        // The proportional product arrives here on the first pass only.
        if (!phase) begin
          acc <= term_neg ? 64'd0 - prod : prod;
        end
        term_neg <= g_neg ^ (phase ? diff_neg : err_neg);
      end
      S_MUL_LO: begin
        part_hi <= prod[63:WORD_W];
      end
      S_MUL_HI: begin
        part_lo <= prod[51:0];
      end
      S_SUM: begin
        sum_hi <= prod[51:0] + 52'(part_lo[51:WORD_W]);
        sum_lo <= part_lo[WORD_W-1:0];
      end
      S_TERM: begin
        // Any bit at or above 2^63 saturates, whichever the sign.
        if (|sum_hi[51:31]) begin
          term <= term_neg ? S64_MIN : S64_MAX;
        end else begin
          term <= term_neg ? 64'd0 - term_m : term_m;
        end
      end
      S_ACC: begin
        if (acc_sum[64] != acc_sum[63]) begin
          acc <= acc_sum[64] ? S64_MIN : S64_MAX;
        end else begin
          acc <= acc_sum[63:0];
        end
        if (!phase) begin
          g_neg <= gain_d[WORD_W-1];
          g_mag <= gain_d[WORD_W-1] ? WORD_W'(0) - gain_d : gain_d;
        end
      end
      S_SHAPE: begin
        ctl_pos <= acc > 64'sd0;
        ctl_mag <= (acc > 64'sd0) ? acc : 64'd0 - acc;
      end
      S_DECIDE: begin
        if (err == '0) begin
          out_q <= '{pwm_duty: PWM_FULL_DUTY, direction: 1'b1, finished: 1'b0,
                     last: (count_inc < STABLE_LIMIT)};
        end else if (ctl_pos) begin
          out_q <= '{pwm_duty: cw_duty, direction: 1'b0, finished: 1'b0, last: 1'b1};
        end else begin
          out_q <= '{pwm_duty: DUTY_TOP_V - ccw_mag, direction: 1'b1, finished: 1'b0,
                     last: 1'b1};
        end
      end
      S_OUT: begin
        // After the last zero-error result the stop result takes its place.
        if (out_acc && second_pending) begin
          out_q <= '{pwm_duty: '0, direction: 1'b0, finished: 1'b1, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // Requests are never taken while a result is still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(request.ready && result.valid))
    else $error("request taken while a result is pending");

  // A stop result always closes its item and leaves the motor undriven.
  a_stop_shape: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.finished |->
      result.last && !result.direction && result.pwm_duty == '0)
    else $error("malformed stop result");

  // The position moves only after an accepted edge item.
  a_pos_edge: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(position) |->
      $past(request.valid && request.ready && request.cmd == CMD_EDGE))
    else $error("position changed without an edge item");

  // The stability run stops counting once it reaches its limit.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    stable_count <= STABLE_LIMIT)
    else $error("stability count overran its limit");

  // Finishing is decided only at the end of a tick.
  a_done_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> $past(state == S_DECIDE) && $past(err == '0))
    else $error("finished flag set outside a zero-error tick");
`endif

endmodule

[tb/encoder_position_pd_motor_drive_tb.sv]
// Self-checking testbench of the encoder position PD motor drive, with its scoreboard.
module encoder_position_pd_motor_drive_tb;
  import epdmd_pkg::*;

  // Saturation bounds of the 64-bit control arithmetic.
  localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_MIN = 64'sh8000_0000_0000_0000;

  // A tick keeps the block busy before its first result; the quiet spell below
  // outlasts a whole tick, which is enough before touching registers.
  localparam int SETTLE_CYCLES  = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 150;

  // Direction of one encoder step.
  localparam bit STEP_UP   = 1'b0;
  localparam bit STEP_DOWN = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic            edge_channel;
    logic            level_a;
    logic            level_b;
    logic [DT_W-1:0] elapsed_us;
  } drive_item_t;

  // The scoreboard keeps its own copy of the position counter, the controller
  // state and the register file. Each accepted request item is worked through
  // here and the results it must cause are queued in order; each result item
  // taken from the block is compared with the oldest of them.
  class motor_drive_scoreboard;
    int      target;
    int      gain_p;
    int      gain_i;
    int      gain_d;
    int      cw_min;
    int      cw_max;
    int      ccw_min;
    int      ccw_max;
    int      position;
    int      previous_error;
    int      stable_count;
    bit      done;
    result_t expected_results[$];
    int      failures;
    int      checked;
    int      edges;
    int      ticks;
    int      steady;
    int      low_drive;
    int      high_drive;
    int      stops;

    function new();
      target  = 0;
      gain_p  = 65536;
      gain_i  = 66;
      gain_d  = 66;
      cw_min  = 50;
      cw_max  = 600;
      ccw_min = 600;
      ccw_max = 700;
    endfunction

    function void write_register(reg_idx_t idx, logic [WORD_W-1:0] value);
      case (idx)
        REG_TARGET:  target  = value;
        REG_GAIN_P:  gain_p  = value;
        REG_GAIN_I:  gain_i  = value;
        REG_GAIN_D:  gain_d  = value;
        REG_CW_MIN:  cw_min  = value[DUTY_W-1:0];
        REG_CW_MAX:  cw_max  = value[DUTY_W-1:0];
        REG_CCW_MIN: ccw_min = value[DUTY_W-1:0];
        REG_CCW_MAX: ccw_max = value[DUTY_W-1:0];
        default: ;
      endcase
    endfunction

    function longint sat_mul(longint a, longint b);
      logic signed [127:0] p;
      logic signed [127:0] q;
      p = a;
      q = b;
      p = p * q;
      if (p > SAT_MAX) return SAT_MAX;
      if (p < SAT_MIN) return SAT_MIN;
      return p[63:0];
    endfunction

    function longint sat_add(longint a, longint b);
      logic signed [64:0] s;
      s = a;
      s = s + b;
      if (s > SAT_MAX) return SAT_MAX;
      if (s < SAT_MIN) return SAT_MIN;
      return s[63:0];
    endfunction

    // Target minus position, saturated to 32 bits.
    function int current_error();
      longint diff;
      diff = longint'(target) - longint'(position);
      if (diff > 64'sd2147483647) diff = 64'sd2147483647;
      if (diff < -64'sd2147483648) diff = -64'sd2147483648;
      return int'(diff);
    endfunction

    function void queue_result(logic [DUTY_W-1:0] duty, logic dir, logic fin, logic lst);
      expected_results.push_back('{pwm_duty: duty, direction: dir, finished: fin, last: lst});
    endfunction

    function void note_request(drive_item_t it);
      longint      e;
      longint      dt;
      longint      ctl;
      longint      lo;
      longint      hi;
      logic [63:0] mag;
      bit          down;
      if (it.cmd == CMD_EDGE) begin
        // Line A counts down when the levels agree, line B when they differ.
        down = (it.edge_channel == CHAN_A) ? (it.level_a == it.level_b)
                                           : (it.level_a != it.level_b);
        position = down ? position - 1 : position + 1;
        edges++;
        return;
      end
      ticks++;
      if (done) begin
        queue_result('0, 1'b0, 1'b1, 1'b1);
        stops++;
        return;
      end
      e   = current_error();
      dt  = it.elapsed_us;
      ctl = sat_mul(gain_p, e);
      ctl = sat_add(ctl, sat_mul(sat_mul(gain_i, e), dt));
      ctl = sat_add(ctl, sat_mul(sat_mul(gain_d, e - previous_error), dt));
      previous_error = int'(e);
      if (e == 0) begin
        steady++;
        if (stable_count < 255) stable_count++;
        if (stable_count >= STABLE_TICKS) begin
          done = 1'b1;
          queue_result(DUTY_W'(PWM_FULL), 1'b1, 1'b0, 1'b0);
          queue_result('0, 1'b0, 1'b1, 1'b1);
          stops++;
        end else begin
          queue_result(DUTY_W'(PWM_FULL), 1'b1, 1'b0, 1'b1);
        end
        return;
      end
      stable_count = 0;
      if (ctl > 0) begin
        hi = longint'(cw_max) * 65536;
        lo = longint'(cw_min) * 65536;
        if (ctl > hi) ctl = hi;
        if (ctl < lo) ctl = lo;
        queue_result(ctl[25:16], 1'b0, 1'b0, 1'b1);
        low_drive++;
      end else begin
        mag = -ctl;
        mag = mag >> 16;
        if (mag > ccw_max) mag = ccw_max;
        if (mag < ccw_min) mag = ccw_min;
        queue_result(DUTY_W'(DUTY_TOP - int'(mag)), 1'b1, 1'b0, 1'b1);
        high_drive++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: pwm_duty %0d direction %0d finished %0d last %0d",
               got.pwm_duty, got.direction, got.finished, got.last);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.pwm_duty !== want.pwm_duty) begin
        $error("pwm_duty: expected %0d, got %0d", want.pwm_duty, got.pwm_duty);
        failures++;
      end
      if (got.direction !== want.direction) begin
        $error("direction: expected %0d, got %0d", want.direction, got.direction);
        failures++;
      end
      if (got.finished !== want.finished) begin
        $error("finished: expected %0d, got %0d", want.finished, got.finished);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             write_enable;
  reg_idx_t         reg_index;
  logic [WORD_W-1:0] write_data;

  epdmd_req_if request_ch ();
  epdmd_res_if result_ch ();

  encoder_position_pd_motor_drive DUT (
    .clk          (clk),
    .rst          (rst),
    .request      (request_ch),
    .result       (result_ch),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  motor_drive_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int settings_used;
  int quiet_cycles;
  bit hold_results;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Every result item the block hands over is checked at the edge it is taken.
  always @(posedge clk) begin : result_monitor
    if (!rst && result_ch.valid && result_ch.ready) begin
      sb.check_result('{pwm_duty: result_ch.pwm_duty, direction: result_ch.direction,
                        finished: result_ch.finished, last: result_ch.last});
    end
  end

  // The watchdog ends a run that has stopped moving: it counts the cycles in
  // which neither channel hands over an item.
  always @(posedge clk) begin
    if (rst || (request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Ready follows the current idling rate, except for one long
  // hold-off, timed here, during which the sender keeps offering items so that
  // a result sits in the output register and the request side stalls behind it.
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one item and returns once it has been accepted, possibly after a
  // few idle cycles. Each call starts just after a rising edge.
  task automatic send_item(drive_item_t it);
    request_ch.valid        <= 1'b1;
    request_ch.cmd          <= it.cmd;
    request_ch.edge_channel <= it.edge_channel;
    request_ch.level_a      <= it.level_a;
    request_ch.level_b      <= it.level_b;
    request_ch.elapsed_us   <= it.elapsed_us;
    do @(posedge clk); while (!request_ch.ready);
    sb.note_request(it);
    while ($urandom_range(99) < send_idle_pct) begin
      request_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_register(reg_idx_t idx, logic [WORD_W-1:0] value);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    @(posedge clk);
    sb.write_register(idx, value);
    write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Lets every pending result drain, then gives the block time to finish any
  // edge or tick still in flight before registers are touched.
  task automatic settle();
    request_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic drive_item_t edge_item(bit down);
    drive_item_t it;
    it.cmd          = CMD_EDGE;
    it.edge_channel = $urandom_range(1);
    it.level_a      = $urandom_range(1);
    it.level_b      = (it.edge_channel == CHAN_A) ? (down ? it.level_a : !it.level_a)
                                                  : (down ? !it.level_a : it.level_a);
    // The elapsed time means nothing on an edge, but its bits still toggle.
    it.elapsed_us   = $urandom;
    return it;
  endfunction

  function automatic drive_item_t tick_item(logic [DT_W-1:0] dt);
    drive_item_t it;
    it.cmd          = CMD_TICK;
    it.edge_channel = $urandom_range(1);
    it.level_a      = $urandom_range(1);
    it.level_b      = $urandom_range(1);
    it.elapsed_us   = dt;
    return it;
  endfunction

  // Mostly realistic millisecond-scale intervals, with zero, the full range
  // and the largest value mixed in.
  function automatic logic [DT_W-1:0] random_dt();
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      2:       return '1;
      default: return $urandom_range(3000, 1);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_gain();
    case ($urandom_range(6))
      0:       return $urandom;
      1:       return '0;
      2:       return $urandom_range(262144) - 131072;
      3:       return $urandom_range(200) - 100;
      4:       return $urandom_range(4 * 65536);
      5:       return $urandom_range(2000);
      default: return (WORD_W'(1) << (WORD_W - 1)) - $urandom_range(1);
    endcase
  endfunction

  // A new register setting for one random phase. The target usually lies a
  // few counts from the present position so that the random walk of the
  // encoder crosses it; one phase takes a target anywhere in the range.
  task automatic random_settings(int phase);
    int near;
    near = sb.position + int'($urandom_range(60)) - 30;
    write_register(REG_TARGET, (phase == 2) ? WORD_W'($urandom) : WORD_W'(near));
    write_register(REG_GAIN_P, random_gain());
    write_register(REG_GAIN_I, random_gain());
    write_register(REG_GAIN_D, random_gain());
    write_register(REG_CW_MIN, $urandom_range(1023));
    write_register(REG_CW_MAX, $urandom_range(1023));
    write_register(REG_CCW_MIN, $urandom_range(1023));
    write_register(REG_CCW_MAX, $urandom_range(1023));
    settings_used++;
  endtask

  // Random traffic: edges drift towards the target more often than away from
  // it, and ticks are likelier once it is reached, so that runs of steady
  // ticks occur. A run is broken by an edge before it could reach the stop
  // count, because the finished state only ends with a reset.
  task automatic run_random(int count);
    int e;
    repeat (count) begin
      e = sb.current_error();
      if (e == 0 && sb.stable_count >= STABLE_TICKS - 1) begin
        send_item(edge_item($urandom_range(1)));
      end else if ((e == 0 && $urandom_range(99) < 75) || $urandom_range(99) < 40) begin
        send_item(tick_item(random_dt()));
      end else if ($urandom_range(99) < 65) begin
        send_item(edge_item(e < 0 ? STEP_DOWN : STEP_UP));
      end else begin
        send_item(edge_item($urandom_range(1)));
      end
    end
  endtask

  task automatic directed_items();
    drive_item_t it;
    // Every line with every pair of levels; the eight steps cancel out.
    for (int ch = 0; ch < 2; ch++) begin
      for (int la = 0; la < 2; la++) begin
        for (int lb = 0; lb < 2; lb++) begin
          it              = edge_item(STEP_UP);
          it.edge_channel = ch;
          it.level_a      = la;
          it.level_b      = lb;
          send_item(it);
        end
      end
    end
    // Zero error with the shortest and the longest interval.
    send_item(tick_item('0));
    send_item(tick_item('1));
    // Small negative error, then a positive one that clamps at the top.
    send_item(edge_item(STEP_UP));
    send_item(tick_item(20'd1000));
    repeat (2) send_item(edge_item(STEP_DOWN));
    send_item(tick_item('1));

    // All gains zero: nonzero error with a control value of exactly zero.
    settle();
    write_register(REG_GAIN_P, '0);
    write_register(REG_GAIN_I, '0);
    write_register(REG_GAIN_D, '0);
    send_item(tick_item(20'd500));

    // Extreme gains and crossed duty limits, where the minimum must win. The
    // error saturates at the bottom and the products hit the 64-bit floor.
    settle();
    write_register(REG_TARGET, 32'h8000_0000);
    write_register(REG_GAIN_P, 32'h7FFF_FFFF);
    write_register(REG_GAIN_I, 32'h7FFF_FFFF);
    write_register(REG_GAIN_D, 32'h8000_0000);
    write_register(REG_CW_MIN, 1023);
    write_register(REG_CW_MAX, 0);
    write_register(REG_CCW_MIN, 1023);
    write_register(REG_CCW_MAX, 0);
    settings_used++;
    repeat (2) send_item(edge_item(STEP_UP));
    send_item(tick_item('1));

    // Error saturated at the top: the saturated terms cancel to minus one.
    settle();
    write_register(REG_TARGET, 32'h7FFF_FFFF);
    repeat (2) send_item(edge_item(STEP_DOWN));
    send_item(tick_item('1));

    // Same error with a steady history: control saturates upwards.
    settle();
    write_register(REG_GAIN_D, 32'h7FFF_FFFF);
    send_item(tick_item('1));
  endtask

  // The stability run: the target is put on the present position and ticks
  // follow until the stop result, then more ticks, edges and a register write
  // show that the block stays finished.
  task automatic finish_run();
    settle();
    write_register(REG_TARGET, sb.position);
    while (!sb.done) send_item(tick_item(random_dt()));
    repeat (3) send_item(tick_item(random_dt()));
    repeat (4) send_item(edge_item($urandom_range(1)));
    settle();
    write_register(REG_TARGET, $urandom);
    write_register(REG_GAIN_P, random_gain());
    repeat (3) send_item(tick_item(random_dt()));
  endtask

  initial begin : stimulus
    request_ch.valid        <= 1'b0;
    request_ch.cmd          <= CMD_EDGE;
    request_ch.edge_channel <= CHAN_A;
    request_ch.level_a      <= 1'b0;
    request_ch.level_b      <= 1'b0;
    request_ch.elapsed_us   <= '0;
    write_enable            <= 1'b0;
    reg_index               <= REG_TARGET;
    write_data              <= '0;
    rst                     <= 1'b1;
    hold_results  = 1'b0;
    settings_used = 1;
    // Slow sender against a very slow receiver first.
    send_idle_pct = 36;
    recv_idle_pct = 88;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      // Idling swaps sides a third of the way through, and the last third runs flat out.
      if (phase == 2) begin
        send_idle_pct = 88;
        recv_idle_pct = 36;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_settings(phase);
      if (phase == RANDOM_PHASES - 1) hold_results = 1'b1;
      run_random(PHASE_ITEMS);
    end

    finish_run();
    settle();

    $display("Run covered %0d items (%0d encoder edges, %0d control ticks) under %0d register settings, %0d results checked.",
             sb.edges + sb.ticks, sb.edges, sb.ticks, settings_used, sb.checked);
    $display("Tick outcomes: %0d steady, %0d low-direction drives, %0d high-direction drives, %0d stop results.",
             sb.steady, sb.low_drive, sb.high_drive, sb.stops);
    if (sb.failures == 0 && sb.expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/epdmd_pkg.sv
rtl/epdmd_if.sv
rtl/encoder_position_pd_motor_drive.sv
tb/encoder_position_pd_motor_drive_tb.sv
